/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PIT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pit2d assertion failed");

// Next-cycle implication, disabled during reset
`define PIT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pit2d assertion failed");

`endif

/* design/pit2d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pit2d_pkg;

   localparam int TOL_WIDTH = 24;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 24'd6554;

   // load strobes for the register stages ahead of the result register
   typedef struct packed {
      logic load_in;
      logic load_diff;
      logic load_prod;
   } pipe_ctl_type;

   // sign of one edge function
   typedef struct packed {
      logic neg;
      logic zero;
   } edge_sign_type;

endpackage

`default_nettype wire

/* design/pit2d_diff_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module pit2d_diff_stage #(
   parameter int COORD_WIDTH = 24
) (
   input  wire logic                          clock,
   input  wire pit2d_pkg::pipe_ctl_type       ctl,
   input  wire logic                          tolerant,
   input  wire logic signed [COORD_WIDTH-1:0] point_u,
   input  wire logic signed [COORD_WIDTH-1:0] point_v,
   input  wire logic signed [COORD_WIDTH-1:0] vertex0_u,
   input  wire logic signed [COORD_WIDTH-1:0] vertex0_v,
   input  wire logic signed [COORD_WIDTH-1:0] vertex1_u,
   input  wire logic signed [COORD_WIDTH-1:0] vertex1_v,
   input  wire logic signed [COORD_WIDTH-1:0] vertex2_u,
   input  wire logic signed [COORD_WIDTH-1:0] vertex2_v,
   output logic                               tolerant_q,
   output logic signed [COORD_WIDTH:0]        t_u,
   output logic signed [COORD_WIDTH:0]        t_v,
   output logic signed [COORD_WIDTH:0]        s_u,
   output logic signed [COORD_WIDTH:0]        s_v,
   output logic signed [COORD_WIDTH:0]        w_u,
   output logic signed [COORD_WIDTH:0]        w_v
);
   import pit2d_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int DW = COORD_WIDTH + 1;

   logic                 tol_ff;
   logic signed [CW-1:0] pu_ff, pv_ff, v0u_ff, v0v_ff, v1u_ff, v1v_ff, v2u_ff, v2v_ff;
   logic                 tol_d_ff;
   logic signed [DW-1:0] tu_ff, tv_ff, su_ff, sv_ff, wu_ff, wv_ff;
   logic signed [DW-1:0] tu_in, tv_in, su_in, sv_in, wu_in, wv_in;

   function automatic logic signed [DW-1:0] sub_ext(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
      sub_ext = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
   endfunction

   always_ff @(posedge clock) begin
      if (ctl.load_in) begin
         tol_ff <= tolerant;
         pu_ff  <= point_u;
         pv_ff  <= point_v;
         v0u_ff <= vertex0_u;
         v0v_ff <= vertex0_v;
         v1u_ff <= vertex1_u;
         v1v_ff <= vertex1_v;
         v2u_ff <= vertex2_u;
         v2v_ff <= vertex2_v;
      end
   end

   always_comb begin
      tu_in = sub_ext(v0u_ff, pu_ff);
      tv_in = sub_ext(v0v_ff, pv_ff);
      su_in = sub_ext(v1u_ff, pu_ff);
      sv_in = sub_ext(v1v_ff, pv_ff);
      wu_in = sub_ext(v2u_ff, pu_ff);
      wv_in = sub_ext(v2v_ff, pv_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_diff) begin
         tol_d_ff <= tol_ff;
         tu_ff    <= tu_in;
         tv_ff    <= tv_in;
         su_ff    <= su_in;
         sv_ff    <= sv_in;
         wu_ff    <= wu_in;
         wv_ff    <= wv_in;
      end
   end

   assign tolerant_q = tol_d_ff;
   assign t_u = tu_ff;
   assign t_v = tv_ff;
   assign s_u = su_ff;
   assign s_v = sv_ff;
   assign w_u = wu_ff;
   assign w_v = wv_ff;

endmodule

`default_nettype wire

/* design/pit2d_edge_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sign of a*b - (c*d - tol): products registered, then one three-way add.
module pit2d_edge_unit #(
   parameter int COORD_WIDTH = 24
) (
   input  wire logic                                  clock,
   input  wire pit2d_pkg::pipe_ctl_type               ctl,
   input  wire logic signed [COORD_WIDTH:0]           a,
   input  wire logic signed [COORD_WIDTH:0]           b,
   input  wire logic signed [COORD_WIDTH:0]           c,
   input  wire logic signed [COORD_WIDTH:0]           d,
   input  wire logic [pit2d_pkg::TOL_WIDTH-1:0]       tol,
   output pit2d_pkg::edge_sign_type                   sign
);
   import pit2d_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int SW = ((PW > TOL_WIDTH) ? PW : TOL_WIDTH) + 2;

   logic signed [PW-1:0]   ab_in, cd_in;
   logic signed [PW-1:0]   ab_ff, cd_ff;
   logic [TOL_WIDTH-1:0]   tol_ff;
   logic signed [SW-1:0]   sum;

   always_comb begin
      ab_in = PW'(a) * PW'(b);
      cd_in = PW'(c) * PW'(d);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_prod) begin
         ab_ff  <= ab_in;
         cd_ff  <= cd_in;
         tol_ff <= tol;
      end
   end

   always_comb begin
      sum = SW'(ab_ff) - SW'(cd_ff) + $signed({{(SW-TOL_WIDTH){1'b0}}, tol_ff});
      sign.neg  = sum[SW-1];
      sign.zero = (sum == '0);
   end

endmodule

`default_nettype wire

/* design/point_in_triangle_2d_top.sv */
// Pipeline: input register loads at req acceptance, then difference,
//    product and result registers; rsp_valid is the result valid bit.
// Throughput: one transaction per cycle unless rsp_ready stalls the pipe;
//    the six products are formed in parallel in one register stage.
// Reset: clears all stage valid bits and loads tolerance with 6554 (0.1);
//    no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module point_in_triangle_2d_top #(
   parameter int COORD_WIDTH = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [pit2d_pkg::TOL_WIDTH-1:0]     csr_wr_data,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_tolerant,
   input  wire logic signed [COORD_WIDTH-1:0]       req_point_u,
   input  wire logic signed [COORD_WIDTH-1:0]       req_point_v,
   input  wire logic signed [COORD_WIDTH-1:0]       req_vertex0_u,
   input  wire logic signed [COORD_WIDTH-1:0]       req_vertex0_v,
   input  wire logic signed [COORD_WIDTH-1:0]       req_vertex1_u,
   input  wire logic signed [COORD_WIDTH-1:0]       req_vertex1_v,
   input  wire logic signed [COORD_WIDTH-1:0]       req_vertex2_u,
   input  wire logic signed [COORD_WIDTH-1:0]       req_vertex2_v,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_inside_res
);
   import pit2d_pkg::*;

   localparam int DW = COORD_WIDTH + 1;

   logic [TOL_WIDTH-1:0] tolerance_ff, tolerance_in;
   logic                 in_vld_ff, in_vld_in;
   logic                 diff_vld_ff, diff_vld_in;
   logic                 prod_vld_ff, prod_vld_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic                 inside_ff, inside_in;
   logic                 adv_in, adv_diff, adv_prod, adv_rsp;
   pipe_ctl_type         ctl;

   logic                 tolerant_d;
   logic signed [DW-1:0] t_u, t_v, s_u, s_v, w_u, w_v;
   logic [TOL_WIDTH-1:0] tol_sel;
   edge_sign_type        e0, e1, e2;

   // stall propagates back through all stages combinationally; bubbles collapse
   always_comb begin
      adv_rsp  = !rsp_vld_ff || rsp_ready;
      adv_prod = !prod_vld_ff || adv_rsp;
      adv_diff = !diff_vld_ff || adv_prod;
      adv_in   = !in_vld_ff || adv_diff;
      ctl.load_in   = req_valid && adv_in;
      ctl.load_diff = in_vld_ff && adv_diff;
      ctl.load_prod = diff_vld_ff && adv_prod;
      in_vld_in   = adv_in   ? req_valid   : in_vld_ff;
      diff_vld_in = adv_diff ? in_vld_ff   : diff_vld_ff;
      prod_vld_in = adv_prod ? diff_vld_ff : prod_vld_ff;
      rsp_vld_in  = adv_rsp  ? prod_vld_ff : rsp_vld_ff;
      tolerance_in = csr_wr_en ? csr_wr_data : tolerance_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         diff_vld_ff  <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         tolerance_ff <= TOL_RESET;
      end else begin
         in_vld_ff    <= in_vld_in;
         diff_vld_ff  <= diff_vld_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
         tolerance_ff <= tolerance_in;
      end
   end

   pit2d_diff_stage #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
      .clock      (clock),
      .ctl        (ctl),
      .tolerant   (req_tolerant),
      .point_u    (req_point_u),
      .point_v    (req_point_v),
      .vertex0_u  (req_vertex0_u),
      .vertex0_v  (req_vertex0_v),
      .vertex1_u  (req_vertex1_u),
      .vertex1_v  (req_vertex1_v),
      .vertex2_u  (req_vertex2_u),
      .vertex2_v  (req_vertex2_v),
      .tolerant_q (tolerant_d),
      .t_u        (t_u),
      .t_v        (t_v),
      .s_u        (s_u),
      .s_v        (s_v),
      .w_u        (w_u),
      .w_v        (w_v)
   );

   assign tol_sel = tolerant_d ? tolerance_ff : '0;

   pit2d_edge_unit #(.COORD_WIDTH(COORD_WIDTH)) u_edge0 (
      .clock (clock), .ctl (ctl),
      .a (t_u), .b (s_v), .c (s_u), .d (t_v), .tol (tol_sel), .sign (e0)
   );

   pit2d_edge_unit #(.COORD_WIDTH(COORD_WIDTH)) u_edge1 (
      .clock (clock), .ctl (ctl),
      .a (s_u), .b (w_v), .c (w_u), .d (s_v), .tol (tol_sel), .sign (e1)
   );

   pit2d_edge_unit #(.COORD_WIDTH(COORD_WIDTH)) u_edge2 (
      .clock (clock), .ctl (ctl),
      .a (w_u), .b (t_v), .c (t_u), .d (w_v), .tol (tol_sel), .sign (e2)
   );

   // first edge strictly positive picks the >= branch, otherwise <=
   always_comb begin
      if (!e0.neg && !e0.zero) begin
         inside_in = !e1.neg && !e2.neg;
      end else begin
         inside_in = (e1.neg || e1.zero) && (e2.neg || e2.zero);
      end
   end

   always_ff @(posedge clock) begin
      if (prod_vld_ff && adv_rsp) begin
         inside_ff <= inside_in;
      end
   end

   assign req_ready      = adv_in;
   assign rsp_valid      = rsp_vld_ff;
   assign rsp_inside_res = inside_ff;

   `PIT_ASSERT_IMP(a_ready_stall, clock, reset, !req_ready, in_vld_ff && diff_vld_ff && prod_vld_ff && rsp_vld_ff && !rsp_ready)
   `PIT_ASSERT_NXT(a_diff_fill, clock, reset, in_vld_ff && adv_diff, diff_vld_ff)
   `PIT_ASSERT_NXT(a_rsp_fill, clock, reset, prod_vld_ff && adv_rsp, rsp_vld_ff)
   `PIT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_vld_ff && !rsp_ready, rsp_vld_ff && $stable(inside_ff))

endmodule

`default_nettype wire
